/* hw/rtl/xrld_pkg.sv */
`default_nettype none

package xrld_pkg;

    localparam int unsigned RUN_W   = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned TOK_MAX = 7;
    localparam int unsigned IDX_W   = 3;

    localparam logic [RUN_W-1:0]   MAX_REGION_BYTES = 16'd65535;
    localparam logic [RUN_W-1:0]   RUN_SPLIT        = 16'h8000;
    localparam logic [RUN_W-1:0]   SHORT_MAX        = 16'h007f;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 17'h1ffff;
    localparam logic [23:0]        SPLIT_TOKEN      = 24'hffff00;

    // saturating add of this item's byte count
    function automatic logic [COUNT_W-1:0] count_add(
        input logic [COUNT_W-1:0] base,
        input logic [IDX_W-1:0]   incr
    );
        logic [COUNT_W:0] sum;
        begin
            sum = {1'b0, base} + {{(COUNT_W+1-IDX_W){1'b0}}, incr};
            count_add = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/xor_run_length_diff_encoder.sv */
`default_nettype none

// XOR run-length difference encoder.
// Input channel (i_s_*): one item per byte pair, current byte in tdata[7:0],
// snapshot byte in tdata[15:8], tlast marks the last pair of a region.
// Output channel (o_m_*): one item per encoded byte. tdata[7:0] is the byte,
// tdata[24:8] the region's total encoded length (only on the end item),
// tuser[0] says the byte is real, tuser[1] marks end of region, tlast marks
// the last result of the input item.
// An input item is encoded in the cycle it is accepted and lands in a token
// buffer; the buffer hands one token per cycle to the output register while
// the receiver is ready, and each result is registered there in turn.
// An item that yields no result (equal bytes, not last) skips the buffer; an
// item yielding k results holds it until its last token moves out, and the
// next item is accepted in that cycle. The single output register drains one
// token a cycle while the receiver is ready, which sets the rate.
// Reset clears the run and byte counters and the buffer and output valid flags.
// When the receiver stalls, the output register holds, the buffer holds,
// and the input stops being ready once the buffer is full; nothing is dropped.
module xor_run_length_diff_encoder
    import xrld_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // current_byte, previous_byte
    input  wire logic        i_s_tlast,   // final_item
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // diff_byte, region_len, zero fill
    output logic [1:0]       o_m_tuser,   // byte_valid, end_of_stream
    output logic             o_m_tlast    // last_of_run
);

    // running state
    logic [RUN_W-1:0]   r_zero_run, n_zero_run;
    logic [COUNT_W-1:0] r_count, n_count;

    // token buffer for one item
    logic                 r_buf_valid, n_buf_valid;
    logic [8*TOK_MAX-1:0] r_tok;
    logic [IDX_W-1:0]     r_k;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_bvalid;
    logic                 r_fin;
    logic [COUNT_W-1:0]   r_len;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_bvalid;
    logic               r_out_last;
    logic               r_out_eos;
    logic [COUNT_W-1:0] r_out_len;

    // encode
    logic [7:0]         x;
    logic               fin;
    logic               big;
    logic [RUN_W-1:0]   j;
    logic [RUN_W-1:0]   m;
    logic               has_run;
    logic               two;
    logic [31:0]        s1;
    logic [IDX_W-1:0]   rn;
    logic [8*TOK_MAX-1:0] tok;
    logic [IDX_W-1:0]   k;
    logic [IDX_W-1:0]   nbytes;
    logic [COUNT_W-1:0] sum_count;

    logic in_acc;
    logic load;
    logic issue;
    logic buf_last;
    logic [7:0] cur_tok;

    assign x   = i_s_tdata[7:0] ^ i_s_tdata[15:8];
    assign fin = i_s_tlast;

    always_comb begin
        big     = r_zero_run > RUN_SPLIT;
        j       = big ? (r_zero_run - RUN_SPLIT) : r_zero_run;
        has_run = (j != '0);
        m       = j - 16'd1;
        two     = m > SHORT_MAX;
        if (!has_run) begin
            s1 = {24'd0, x};
            rn = 3'd0;
        end else if (!two) begin
            s1 = {8'd0, x, m[7:0], 8'h00};
            rn = 3'd2;
        end else begin
            s1 = {x, m[14:7], 1'b1, m[6:0], 8'h00};
            rn = 3'd3;
        end
        if (x == 8'd0) begin
            // end-only result on an equal final byte
            tok    = '0;
            k      = 3'd1;
            nbytes = 3'd0;
        end else begin
            tok    = big ? {s1, SPLIT_TOKEN} : {24'd0, s1};
            k      = (big ? 3'd3 : 3'd0) + rn + 3'd1;
            nbytes = k;
        end
        sum_count = count_add(r_count, nbytes);
    end

    // handshake
    assign cur_tok  = r_tok[{r_idx, 3'b000} +: 8];
    assign buf_last = (r_idx == r_k - 3'd1);
    assign issue    = r_buf_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_buf_valid || (issue && buf_last);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign load     = in_acc && ((x != 8'd0) || fin);

    always_comb begin
        n_zero_run = r_zero_run;
        n_count    = r_count;
        if (in_acc) begin
            if (x == 8'd0) begin
                if (r_zero_run < MAX_REGION_BYTES) begin
                    n_zero_run = r_zero_run + 16'd1;
                end
            end else begin
                n_zero_run = '0;
            end
            n_count = sum_count;
            if (fin) begin
                n_zero_run = '0;
                n_count    = '0;
            end
        end
    end

    always_comb begin
        n_buf_valid = r_buf_valid;
        n_idx       = r_idx;
        if (issue) begin
            if (buf_last) begin
                n_buf_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (load) begin
            n_buf_valid = 1'b1;
            n_idx       = '0;
        end
        n_out_valid = r_out_valid;
        if (issue) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run  <= '0;
            r_count     <= '0;
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_zero_run  <= n_zero_run;
            r_count     <= n_count;
            r_buf_valid <= n_buf_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok    <= tok;
            r_k      <= k;
            r_bvalid <= (x != 8'd0);
            r_fin    <= fin;
            r_len    <= sum_count;
        end
        if (issue) begin
            r_out_byte   <= cur_tok;
            r_out_bvalid <= r_bvalid;
            r_out_last   <= buf_last;
            r_out_eos    <= buf_last && r_fin;
            r_out_len    <= (buf_last && r_fin) ? r_len : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_len, r_out_byte};
    assign o_m_tuser  = {r_out_eos, r_out_bvalid};
    assign o_m_tlast  = r_out_last;

    // checks
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid |-> (r_idx < r_k))
        else $error("token index past item end");

    a_eos_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eos) |-> r_out_last)
        else $error("end of region not on last result");

    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bvalid) |-> (r_out_eos && r_out_byte == 8'd0))
        else $error("end-only result outside region end");

    a_no_load_over_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf_valid && !issue) |-> !in_acc)
        else $error("item accepted while token buffer busy");

endmodule

`default_nettype wire
